// ===== rtl/bdeq_pkg.sv =====
package bdeq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic exec;        // carry out a single-result command from the input
    logic dump_start;  // load the dump cursor from the front of the queue
    logic emit;        // place the word read at the cursor in the output register
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic out_free;    // output register is empty or being taken this cycle
    logic dump_last;   // the cursor points at the back word
  } stat_t;

endpackage

// ===== rtl/bdeq_ctrl.sv =====
module bdeq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [2:0]          command,
  input  bdeq_pkg::stat_t     stat,
  output bdeq_pkg::ctl_t      ctl
);
  import bdeq_pkg::*;

  state_t state;
  state_t state_next;
  logic   take;
  logic   is_dump;

  assign is_dump = (command == CMD_DUMP);
  assign take    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take && is_dump && !stat.empty) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (stat.out_free) begin
          state_next = stat.dump_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    ctl.exec       = 1'b0;
    ctl.dump_start = 1'b0;
    ctl.emit       = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready       = stat.out_free;
        // A dump of an empty queue answers with a single status result.
        ctl.exec       = take && !(is_dump && !stat.empty);
        ctl.dump_start = take && is_dump && !stat.empty;
      end
      S_SEND: begin
        ctl.emit = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/bdeq_dpath.sv =====
module bdeq_dpath #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  bdeq_pkg::ctl_t     ctl,
  output bdeq_pkg::stat_t    stat,
  input  logic [2:0]         command,
  input  logic [31:0]        value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [31:0]        out_data,
  output logic               out_last
);
  import bdeq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);

  logic [31:0]   mem [DEPTH];
  logic [IW-1:0] front;
  logic [OW-1:0] occ;
  logic [IW-1:0] cursor;
  logic [OW-1:0] cnt;
  logic [31:0]   rd_data;

  logic          full;
  logic          empty;
  logic [IW-1:0] front_inc;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] cursor_inc;
  logic [OW:0]   back_sum;
  logic [IW-1:0] back_pos;
  logic          do_push;
  logic [IW-1:0] wr_addr;
  status_t       exec_status;

  assign full  = (occ == OW'(DEPTH));
  assign empty = (occ == '0);

  assign front_inc  = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
  assign front_dec  = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
  assign cursor_inc = (cursor == IW'(DEPTH - 1)) ? '0 : cursor + IW'(1);

  // The back slot is front + occupancy, folded once into the ring.
  assign back_sum = {1'b0, occ} + (OW + 1)'(front);
  assign back_pos = (back_sum >= (OW + 1)'(DEPTH)) ? IW'(back_sum - (OW + 1)'(DEPTH))
                                                   : IW'(back_sum);

  assign do_push = ctl.exec && !full &&
                   (command == CMD_PUSH_FRONT || command == CMD_PUSH_BACK);
  assign wr_addr = (command == CMD_PUSH_FRONT) ? front_dec : back_pos;

  always_comb begin
    case (command)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: exec_status = full ? ST_FULL : ST_OK;
      CMD_POP_FRONT, CMD_POP_BACK, CMD_DUMP: exec_status = empty ? ST_EMPTY : ST_OK;
      default: exec_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_addr] <= value;
    end
    rd_data <= mem[cursor];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      occ   <= '0;
    end else if (ctl.exec) begin
      case (command)
        CMD_PUSH_FRONT: begin
          if (!full) begin
            front <= front_dec;
            occ   <= occ + OW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          if (!full) begin
            occ <= occ + OW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (!empty) begin
            front <= front_inc;
            occ   <= occ - OW'(1);
          end
        end
        CMD_POP_BACK: begin
          if (!empty) begin
            occ <= occ - OW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      cnt    <= '0;
    end else if (ctl.dump_start) begin
      cursor <= front;
      cnt    <= '0;
    end else if (ctl.emit) begin
      cursor <= cursor_inc;
      cnt    <= cnt + OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.exec || ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_status <= exec_status;
      out_data   <= '0;
      out_last   <= 1'b1;
    end else if (ctl.emit) begin
      out_status <= ST_OK;
      out_data   <= rd_data;
      out_last   <= stat.dump_last;
    end
  end

  assign stat.empty     = empty;
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.dump_last = (cnt + OW'(1) == occ);

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(DEPTH))
    else $error("occupancy above depth");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && full && (command == CMD_PUSH_FRONT || command == CMD_PUSH_BACK)
    |=> $stable(occ) && $stable(front))
    else $error("push on a full queue changed the state");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (cnt < occ))
    else $error("dump cursor ran past the back word");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec || ctl.emit) |-> (!out_valid || out_ready))
    else $error("output register overwritten while a result was pending");

  a_dump_keeps_state: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> $stable(occ) && $stable(front))
    else $error("queue state changed during a dump");
`endif

endmodule

// ===== rtl/bounded_double_ended_queue_unit.sv =====
// Bounded double-ended queue of signed 32-bit words held in a ring of DEPTH
// entries. Commands arrive on the s_ channel: s_tuser carries the command
// (push front, push back, pop front, pop back, dump) and s_tdata the word
// to push. Results leave on the m_ channel with the status in m_tuser, the
// word in m_tdata and m_tlast set on the final result of each command.
// Push, pop and an empty dump give one result, registered in the cycle
// after the transaction, and a new command is taken in the same cycle as
// the previous result is taken, so single-result commands run at one per
// cycle while the receiver keeps m_tready high.
// A dump of a non-empty queue streams its words one at a time, front to
// back, as the controller alternates a registered read of the ring memory
// (S_READ) with the load of the output register (S_SEND), which waits
// while the receiver stalls; no new command is taken until the dump's
// last word is in the output register.
// When the receiver stalls, the result stays in the output register and
// s_tready falls. Reset empties the queue and clears any pending result;
// the ring contents are not cleared and are never read before written.
module bounded_double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [2:0]  s_tuser,   // [2:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] data
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);
  import bdeq_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  bdeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (s_tuser),
    .stat     (stat),
    .ctl      (ctl)
  );

  bdeq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .command    (s_tuser),
    .value      (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_data   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

// ===== sim/bounded_double_ended_queue_unit_tb.sv =====
`timescale 1ns / 100ps

module bounded_double_ended_queue_unit_tb;
  import bdeq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
  localparam logic [2:0] CMD_RESERVED_MID = 3'd6;
  localparam logic [2:0] CMD_RESERVED_HI = 3'd7;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] word;
  } cmd_item_t;

  typedef struct {
    status_t     status;
    logic [31:0] data;
    logic        last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value
  logic [2:0]  s_tuser = '0;   // [2:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] data
  logic [1:0]  m_tuser;        // [1:0] status
  logic        m_tlast;

  cmd_item_t   cmd_backlog[$];
  reply_t      expected_replies[$];

  // Own copy of the deque state.
  logic [31:0] ring [QUEUE_DEPTH];
  int          head = 0;
  int          fill = 0;

  int          errors = 0;
  int          items_added = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          idle_cycles = 0;
  logic        no_idle = 1'b0;
  logic        hold_off = 1'b0;

  bounded_double_ended_queue_unit #(
    .DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic expect_reply(input status_t st, input logic [31:0] d, input logic l);
    reply_t r;
    r.status = st;
    r.data = d;
    r.last = l;
    expected_replies.push_back(r);
  endtask

  // Applies one accepted command to the deque copy and queues its replies.
  task automatic deque_apply(input logic [2:0] cmd, input logic [31:0] word);
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (fill == QUEUE_DEPTH) begin
          expect_reply(ST_FULL, '0, 1'b1);
        end else begin
          head = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
          ring[head] = word;
          fill++;
          expect_reply(ST_OK, '0, 1'b1);
        end
      end
      CMD_PUSH_BACK: begin
        if (fill == QUEUE_DEPTH) begin
          expect_reply(ST_FULL, '0, 1'b1);
        end else begin
          ring[(head + fill) % QUEUE_DEPTH] = word;
          fill++;
          expect_reply(ST_OK, '0, 1'b1);
        end
      end
      CMD_POP_FRONT: begin
        if (fill == 0) begin
          expect_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          head = (head + 1) % QUEUE_DEPTH;
          fill--;
          expect_reply(ST_OK, '0, 1'b1);
        end
      end
      CMD_POP_BACK: begin
        if (fill == 0) begin
          expect_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          fill--;
          expect_reply(ST_OK, '0, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (fill == 0) begin
          expect_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < fill; i++) begin
            expect_reply(ST_OK, ring[(head + i) % QUEUE_DEPTH], i == fill - 1);
          end
        end
      end
      // Reserved codes leave the state alone but still answer once.
      default: expect_reply(ST_OK, '0, 1'b1);
    endcase
  endtask

  function automatic int pick_gap(input logic quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input logic [2:0] cmd, input logic [31:0] word);
    cmd_item_t it;
    it.cmd = cmd;
    it.word = word;
    cmd_backlog.push_back(it);
    items_added++;
  endtask

  task automatic add_reserved();
    add_item(3'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI)), rand_word());
  endtask

  task automatic add_push();
    if ($urandom_range(0, 1)) add_item(CMD_PUSH_FRONT, rand_word());
    else add_item(CMD_PUSH_BACK, rand_word());
  endtask

  task automatic add_pop();
    if ($urandom_range(0, 1)) add_item(CMD_POP_FRONT, rand_word());
    else add_item(CMD_POP_BACK, rand_word());
  endtask

  // Mostly fill and drain bursts that reach the full and empty ends, with
  // mixed traffic and some raw noise in between.
  task automatic random_episode();
    int kind;
    int n;
    int r;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      n = $urandom_range(12, 20);
      repeat (n) add_push();
      add_item(CMD_DUMP, rand_word());
    end else if (kind < 6) begin
      n = $urandom_range(4, 18);
      repeat (n) add_pop();
      add_item(CMD_DUMP, rand_word());
    end else if (kind < 9) begin
      n = $urandom_range(6, 14);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 40) add_push();
        else if (r < 75) add_pop();
        else if (r < 90) add_item(CMD_DUMP, rand_word());
        else add_reserved();
      end
    end else begin
      n = $urandom_range(2, 5);
      repeat (n) add_item(3'($urandom_range(0, 7)), $urandom);
    end
  endtask

  task automatic random_items(input int count);
    int start;
    start = items_added;
    while (items_added - start < count) random_episode();
  endtask

  // Checked on the falling edge, once the driver and monitor have settled.
  task automatic wait_drained();
    while (cmd_backlog.size() > 0 || s_tvalid || expected_replies.size() > 0)
      @(negedge clk);
  endtask

  // Sender: offers the backlog with random gaps between transactions.
  always @(posedge clk) begin
    cmd_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) deque_apply(s_tuser, s_tdata);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          it = cmd_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= it.cmd;
          s_tdata <= it.word;
          send_gap = pick_gap(no_idle);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction and stalls at random.
  always @(posedge clk) begin
    reply_t want;
    if (m_tvalid && m_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("result with nothing expected, data", m_tdata, '0);
      end else begin
        want = expected_replies.pop_front();
        if (m_tuser !== want.status)
          report_mismatch("status", 32'(m_tuser), 32'(want.status));
        if (m_tdata !== want.data) report_mismatch("data", m_tdata, want.data);
        if (m_tlast !== want.last)
          report_mismatch("last", 32'(m_tlast), 32'(want.last));
      end
    end
    if (rst || hold_off) begin
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else begin
      recv_gap = pick_gap(no_idle);
      m_tready <= (recv_gap == 0);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cases, extreme words at both ends, reserved codes.
    no_idle <= 1'b1;
    add_item(CMD_DUMP, 32'h0);
    add_item(CMD_POP_FRONT, 32'hFFFF_FFFF);
    add_item(CMD_POP_BACK, 32'h0);
    add_item(CMD_PUSH_BACK, 32'h7FFF_FFFF);
    add_item(CMD_PUSH_FRONT, 32'h8000_0000);
    add_item(CMD_PUSH_BACK, 32'h0000_0000);
    add_item(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    add_item(CMD_DUMP, 32'hFFFF_FFFF);
    add_item(CMD_POP_FRONT, 32'h0);
    add_item(CMD_POP_BACK, 32'h0);
    add_item(CMD_DUMP, 32'h0);
    add_item(CMD_RESERVED_LO, 32'hFFFF_FFFF);
    add_item(CMD_RESERVED_HI, 32'h8000_0000);
    add_item(CMD_RESERVED_MID, 32'h5555_AAAA);
    add_item(CMD_POP_FRONT, 32'h0);
    add_item(CMD_POP_BACK, 32'h0);
    add_item(CMD_POP_FRONT, 32'h0);
    add_item(CMD_POP_BACK, 32'h0);
    add_item(CMD_DUMP, 32'h0);
    wait_drained();

    random_items(70);
    wait_drained();

    no_idle <= 1'b0;
    random_items(90);
    wait_drained();

    // The receiver holds off while the sender keeps offering pushes, so the
    // output register fills and the input stalls.
    no_idle <= 1'b1;
    repeat (22) add_push();
    add_item(CMD_DUMP, rand_word());
    repeat (4) add_pop();
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
    wait_drained();

    no_idle <= 1'b0;
    random_items(50);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0 && cmd_backlog.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bdeq_pkg.sv
rtl/bdeq_ctrl.sv
rtl/bdeq_dpath.sv
rtl/bounded_double_ended_queue_unit.sv
sim/bounded_double_ended_queue_unit_tb.sv
